@@ hw/rtl/mm4_pkg.sv @@
package mm4_pkg;

  localparam int ELEM_W    = 32;
  localparam int IDX_W     = 4;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * ELEM_W;

  typedef enum logic {
    MM4_IDLE,
    MM4_ISSUE
  } mm4_state_t;

  typedef struct packed {
    logic store_wr;
    logic issue;
    logic first_k;
    logic last_k;
    logic last_elem;
  } mm4_cmd_t;

endpackage

@@ hw/rtl/mm4_in_if.sv @@
interface mm4_in_if
  import mm4_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     operand_select;
  logic [IDX_W-1:0]         element_index;
  logic signed [ELEM_W-1:0] element_value;
  logic                     compute_after;

  modport source (
    output valid, operand_select, element_index, element_value, compute_after,
    input  ready
  );

  modport sink (
    input  valid, operand_select, element_index, element_value, compute_after,
    output ready
  );
endinterface

@@ hw/rtl/mm4_out_if.sv @@
interface mm4_out_if
  import mm4_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         result_index;
  logic signed [ELEM_W-1:0] result_value;
  logic                     last_result;

  modport source (
    output valid, result_index, result_value, last_result,
    input  ready
  );

  modport sink (
    input  valid, result_index, result_value, last_result,
    output ready
  );
endinterface

@@ hw/rtl/mm4_ctrl.sv @@
module mm4_ctrl
  import mm4_pkg::*;
#(
  parameter int DIM = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   compute_after,
  output logic                   in_ready,
  input  logic                   advance,
  output mm4_cmd_t               cmd,
  output logic [$clog2(DIM)-1:0] row,
  output logic [$clog2(DIM)-1:0] col,
  output logic [$clog2(DIM)-1:0] k
);

  localparam int CNT_W = $clog2(DIM);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIM - 1);

  mm4_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM4_IDLE;
      k_r     <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      MM4_IDLE: begin
        in_ready     = 1'b1;
        cmd.store_wr = in_valid;
        if (in_valid && compute_after) begin
          state_nxt = MM4_ISSUE;
          k_nxt     = '0;
          row_nxt   = '0;
          col_nxt   = '0;
        end
      end
      MM4_ISSUE: begin
        cmd.issue     = 1'b1;
        cmd.first_k   = (k_r == '0);
        cmd.last_k    = (k_r == CNT_LAST);
        cmd.last_elem = (row_r == CNT_LAST) && (col_r == CNT_LAST);
        if (advance) begin
          if (k_r != CNT_LAST) begin
            k_nxt = k_r + 1'b1;
          end else begin
            k_nxt = '0;
            if (row_r != CNT_LAST) begin
              row_nxt = row_r + 1'b1;
            end else begin
              row_nxt = '0;
              if (col_r != CNT_LAST) begin
                col_nxt = col_r + 1'b1;
              end else begin
                col_nxt   = '0;
                state_nxt = MM4_IDLE;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = MM4_IDLE;
      end
    endcase
  end

  assign row = row_r;
  assign col = col_r;
  assign k   = k_r;

endmodule

@@ hw/rtl/mm4_datapath.sv @@
module mm4_datapath
  import mm4_pkg::*;
#(
  parameter int DIM        = 4,
  parameter int WORD_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mm4_cmd_t                 cmd,
  input  logic [$clog2(DIM)-1:0]   row,
  input  logic [$clog2(DIM)-1:0]   col,
  input  logic [$clog2(DIM)-1:0]   k,
  input  logic                     wr_sel,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic signed [ELEM_W-1:0] wr_value,
  output logic                     advance,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_index,
  output logic signed [ELEM_W-1:0] out_value,
  output logic                     out_last
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int EXT_W = AW + IDX_W;
  localparam int ACC_W = PROD_W + $clog2(DIM);
  localparam int SH_W  = ACC_W - FRAC_BITS;
  localparam logic signed [SH_W-1:0] SAT_MAX =
    {{(SH_W - WORD_WIDTH + 1){1'b0}}, {(WORD_WIDTH - 1){1'b1}}};
  localparam logic signed [SH_W-1:0] SAT_MIN = ~SAT_MAX;

  logic [ELEM_W-1:0] left_mem  [CELLS];
  logic [ELEM_W-1:0] right_mem [CELLS];
  logic [CELLS-1:0]  left_vld_r;
  logic [CELLS-1:0]  right_vld_r;

  logic [EXT_W-1:0] idx_ext;
  logic             in_range;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    left_addr;
  logic [AW-1:0]    right_addr;
  logic [AW-1:0]    pos;

  logic [ELEM_W-1:0] left_rd_r, right_rd_r;
  logic              left_rv_r, right_rv_r;
  logic              s1_vld_r, s1_first_r, s1_last_r, s1_elast_r;
  logic [AW-1:0]     s1_pos_r;

  logic signed [ELEM_W-1:0] left_op, right_op;
  logic signed [PROD_W-1:0] prod_r;
  logic                     s2_vld_r, s2_first_r, s2_last_r, s2_elast_r;
  logic [AW-1:0]            s2_pos_r;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    s3_vld_r, s3_elast_r;
  logic [AW-1:0]           s3_pos_r;

  logic signed [SH_W-1:0] shifted;
  logic signed [SH_W-1:0] sat;

  logic                     out_vld_r;
  logic [IDX_W-1:0]         out_index_r;
  logic signed [ELEM_W-1:0] out_value_r;
  logic                     out_last_r;

  assign advance  = !out_vld_r || out_ready;
  assign idx_ext  = EXT_W'(wr_idx);
  assign in_range = idx_ext < EXT_W'(CELLS);
  assign wr_addr  = idx_ext[AW-1:0];

  assign left_addr  = AW'(row) + AW'(AW'(DIM) * AW'(k));
  assign right_addr = AW'(k) + AW'(AW'(DIM) * AW'(col));
  assign pos        = AW'(row) + AW'(AW'(DIM) * AW'(col));

  always_ff @(posedge clk) begin
    if (cmd.store_wr && in_range) begin
      if (wr_sel) begin
        right_mem[wr_addr] <= wr_value;
      end else begin
        left_mem[wr_addr] <= wr_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_vld_r  <= '0;
      right_vld_r <= '0;
    end else if (cmd.store_wr && in_range) begin
      if (wr_sel) begin
        right_vld_r[wr_addr] <= 1'b1;
      end else begin
        left_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_rd_r  <= left_mem[left_addr];
      right_rd_r <= right_mem[right_addr];
      left_rv_r  <= left_vld_r[left_addr];
      right_rv_r <= right_vld_r[right_addr];
      s1_first_r <= cmd.first_k;
      s1_last_r  <= cmd.last_k;
      s1_elast_r <= cmd.last_elem;
      s1_pos_r   <= pos;
    end
  end

  assign left_op  = left_rv_r  ? $signed(left_rd_r)  : '0;
  assign right_op = right_rv_r ? $signed(right_rd_r) : '0;

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r     <= $signed(left_op) * $signed(right_op);
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_elast_r <= s1_elast_r;
      s2_pos_r   <= s1_pos_r;
    end
  end

  always_comb begin
    if (s2_first_r) begin
      acc_nxt = ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_vld_r) begin
      acc_r      <= acc_nxt;
      s3_elast_r <= s2_elast_r;
      s3_pos_r   <= s2_pos_r;
    end
  end

  assign shifted = SH_W'(acc_r >>> FRAC_BITS);

  always_comb begin
    if (shifted > SAT_MAX) begin
      sat = SAT_MAX;
    end else if (shifted < SAT_MIN) begin
      sat = SAT_MIN;
    end else begin
      sat = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s3_vld_r) begin
      out_index_r <= IDX_W'(s3_pos_r);
      out_value_r <= sat[ELEM_W-1:0];
      out_last_r  <= s3_elast_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r  <= cmd.issue;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r && s2_last_r;
      out_vld_r <= s3_vld_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_index = out_index_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

@@ hw/rtl/matrix_multiply_4x4.sv @@
// DIM x DIM fixed-point matrix multiplier, signed Q16.16 elements.
// The input channel carries one beat per operand element: operand_select
// picks the left or right store, element_index is the column-major position
// (row plus DIM times column), and an index beyond the matrix is not stored.
// A beat with compute_after set stores its element first and then starts
// the product. The result channel then carries DIM*DIM beats in column-major
// order with last_result on the final one. Each element is the exact sum of
// DIM products, shifted right by 16 (floor) and saturated to WORD_WIDTH bits.
// A product is issued as one multiply-accumulate per cycle while the
// receiver does not stall, through one read port on each store. The input
// channel is not ready while products are being issued.
// Reset empties the pipeline and makes both stores read as zero. When the
// receiver stalls, the whole pipeline holds and no result is dropped.
module matrix_multiply_4x4
  import mm4_pkg::*;
#(
  parameter int DIM        = 4,
  parameter int WORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  mm4_in_if.sink    in_ch,
  mm4_out_if.source out_ch
);

  localparam int CELLS = DIM * DIM;
  localparam int CNT_W = $clog2(DIM);

  mm4_cmd_t         ctrl_cmd;
  logic             advance;
  logic [CNT_W-1:0] row;
  logic [CNT_W-1:0] col;
  logic [CNT_W-1:0] k;

  mm4_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .compute_after (in_ch.compute_after),
    .in_ready      (in_ch.ready),
    .advance       (advance),
    .cmd           (ctrl_cmd),
    .row           (row),
    .col           (col),
    .k             (k)
  );

  mm4_datapath #(
    .DIM        (DIM),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ctrl_cmd),
    .row       (row),
    .col       (col),
    .k         (k),
    .wr_sel    (in_ch.operand_select),
    .wr_idx    (in_ch.element_index),
    .wr_value  (in_ch.element_value),
    .advance   (advance),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_index (out_ch.result_index),
    .out_value (out_ch.result_value),
    .out_last  (out_ch.last_result)
  );

  // Stores must not change while products are being issued.
  a_no_load_during_issue: assert property (
    @(posedge clk) disable iff (!rst_n) ctrl_cmd.issue |-> !in_ch.ready
  ) else $error("input ready while products are issued");

  // A compute request starts issuing in the next cycle.
  a_issue_follows_request: assert property (
    @(posedge clk) disable iff (!rst_n)
      (in_ch.valid && in_ch.ready && in_ch.compute_after) |=> ctrl_cmd.issue
  ) else $error("compute request did not start issue");

  // The final beat carries the position of the last element.
  a_last_position: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_ch.valid && out_ch.last_result) |->
        (out_ch.result_index == IDX_W'(CELLS - 1))
  ) else $error("last result at wrong position");

endmodule
